// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(name, expr, msg) \
  `ASSERT_PROP(name, !(expr), msg)

`endif

// ===== src/fhc_pkg.sv =====
// ----------------------------------------------------------------------------
// Fronthaul header classifier package
// Shared constants, codes and the record types passed between the stages.
// ----------------------------------------------------------------------------
package fhc_pkg;

  // Frame byte counter, saturating
  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] CountMax = '1;

  // L2 payload offset
  localparam int unsigned OffW = 5;
  localparam logic [OffW-1:0] L2Offset = 5'd14;
  localparam logic [OffW-1:0] TagLen   = 5'd4;
  localparam logic [1:0]      MaxTags  = 2'd2;

  // eCPRI common, message, application and section header bytes kept
  localparam int unsigned EcpriBytes = 16;
  localparam int unsigned EcptrW     = $clog2(EcpriBytes);

  // Bytes needed after the L2 offset for each header level
  localparam logic [CountW-1:0] HdrCommonLen = 17'd4;
  localparam logic [CountW-1:0] MsgHdrEnd    = 17'd8;
  localparam logic [CountW-1:0] AppHdrEnd    = 17'd12;
  localparam logic [CountW-1:0] CSectEnd     = 17'd14;
  localparam logic [CountW-1:0] USectEnd     = 17'd16;
  localparam logic [15:0]       MinPayload   = 16'd4;

  // EtherTypes and TPIDs
  localparam logic [15:0] TpidCtag   = 16'h8100;
  localparam logic [15:0] TpidStag   = 16'h88A8;
  localparam logic [15:0] EtypeEcpri = 16'hAEFE;
  localparam logic [15:0] EtypePtp   = 16'h88F7;

  // eCPRI message types and revision
  localparam logic [7:0] MsgIq    = 8'h00;
  localparam logic [7:0] MsgRtc   = 8'h02;
  localparam logic [7:0] MsgDelay = 8'h05;
  localparam logic [3:0] EcpriRev = 4'd1;

  // Plane codes of the result
  localparam logic [2:0] PlaneNone  = 3'd0;
  localparam logic [2:0] PlaneU     = 3'd1;
  localparam logic [2:0] PlaneC     = 3'd2;
  localparam logic [2:0] PlaneDelay = 3'd3;
  localparam logic [2:0] PlanePtp   = 3'd4;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    KindOther = 2'd0,
    KindPtp   = 2'd1,
    KindEcpri = 2'd2
  } fhc_kind_e;

  // Per-frame summary produced by the front end
  typedef struct packed {
    logic [CountW-1:0]            plen;
    logic [OffW-1:0]              off;
    logic [1:0]                   tags;
    logic                         typ_done;
    fhc_kind_e                    kind;
    logic [11:0]                  vid_outer;
    logic [11:0]                  vid_inner;
    logic [EcpriBytes-1:0][7:0]   ehdr;
  } fhc_frame_t;

  // One result item
  typedef struct packed {
    logic [2:0]  plane;
    logic        malformed;
    logic [1:0]  vlan_tags;
    logic [11:0] outer_vlan;
    logic [11:0] inner_vlan;
    logic        concat_bit;
    logic [15:0] payload_len;
    logic [15:0] eaxc_id;
    logic [15:0] seq_id;
    logic [31:0] radio_header_word;
    logic [31:0] section_word;
  } fhc_result_t;

endpackage

// ===== src/fhc_intf.sv =====
// ----------------------------------------------------------------------------
// Fronthaul header classifier channels
// Byte stream input channel and result output channel, valid/ready.
// ----------------------------------------------------------------------------
interface fhc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

interface fhc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  plane;
  logic        malformed;
  logic [1:0]  vlan_tags;
  logic [11:0] outer_vlan;
  logic [11:0] inner_vlan;
  logic        concat_bit;
  logic [15:0] payload_len;
  logic [15:0] eaxc_id;
  logic [15:0] seq_id;
  logic [31:0] radio_header_word;
  logic [31:0] section_word;

  modport source (
    output valid, plane, malformed, vlan_tags, outer_vlan, inner_vlan, concat_bit,
           payload_len, eaxc_id, seq_id, radio_header_word, section_word,
    input  ready
  );
  modport sink (
    input  valid, plane, malformed, vlan_tags, outer_vlan, inner_vlan, concat_bit,
           payload_len, eaxc_id, seq_id, radio_header_word, section_word,
    output ready
  );
endinterface

// ===== src/fhc_front.sv =====
// ----------------------------------------------------------------------------
// Fronthaul header classifier front end
// Takes one byte per cycle while the queue is not full, strips VLAN tags,
// finds the EtherType and captures the eCPRI header bytes on the fly; pushes
// a frame summary on the last byte of each frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fhc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  fhc_rx_if.sink              rx_i,
  input  logic                full_i,
  output logic                push_o,
  output fhc_pkg::fhc_frame_t frame_o
);
  import fhc_pkg::*;

  logic                       accept;
  logic [15:0]                typ;
  logic                       is_tag;
  logic [OffW-1:0]            off_m1;
  logic [OffW-1:0]            off_m3;
  logic                       at_type;
  logic                       at_vid;
  logic [1:0]                 tags_now;

  // Per-frame control state
  logic [CountW-1:0]          pos_q, pos_d;
  logic [OffW-1:0]            off_q, off_d;
  logic [1:0]                 tags_q, tags_d;
  logic                       pend_q, pend_d;
  logic                       done_q, done_d;
  fhc_kind_e                  kind_q, kind_d;
  logic [EcptrW:0]            ecnt_q, ecnt_d;

  // Captured payload
  logic [7:0]                 prev_q;
  logic [11:0]                vid0_q, vid0_d;
  logic [11:0]                vid1_q, vid1_d;
  logic [EcpriBytes-1:0][7:0] ehdr_q, ehdr_d;

  // Values after this byte, before the end-of-frame restart
  logic [CountW-1:0]          upd_plen;
  logic [OffW-1:0]            upd_off;
  logic [1:0]                 upd_tags;
  logic                       upd_pend;
  logic                       upd_done;
  fhc_kind_e                  upd_kind;
  logic [EcptrW:0]            upd_ecnt;

  assign rx_i.ready = !full_i;
  assign accept     = rx_i.valid && rx_i.ready;

  // Type / tag position decode
  assign typ      = {prev_q, rx_i.rx_byte};
  assign is_tag   = (typ == TpidCtag) || (typ == TpidStag);
  assign off_m1   = off_q - 5'd1;
  assign off_m3   = off_q - 5'd3;
  assign at_type  = !done_q && (pos_q == {{(CountW-OffW){1'b0}}, off_m1});
  assign at_vid   = pend_q && (pos_q == {{(CountW-OffW){1'b0}}, off_m3});
  assign tags_now = tags_q + {1'b0, pend_q};

  // Per-byte parse update
  always_comb begin
    upd_plen = (pos_q == CountMax) ? pos_q : pos_q + 1'b1;
    upd_off  = off_q;
    upd_tags = tags_q;
    upd_pend = pend_q;
    upd_done = done_q;
    upd_kind = kind_q;
    upd_ecnt = ecnt_q;
    vid0_d   = vid0_q;
    vid1_d   = vid1_q;
    ehdr_d   = ehdr_q;

    // VLAN ID of the tag being read
    if (at_vid) begin
      if (tags_q == 2'd0) begin
        vid0_d = {prev_q[3:0], rx_i.rx_byte};
      end else begin
        vid1_d = {prev_q[3:0], rx_i.rx_byte};
      end
    end

    // TPID or EtherType complete: open another tag or settle the kind
    if (at_type) begin
      upd_tags = tags_now;
      upd_pend = 1'b0;
      if (is_tag && (tags_now != MaxTags)) begin
        upd_pend = 1'b1;
        upd_off  = off_q + TagLen;
      end else begin
        upd_done = 1'b1;
        if (typ == EtypePtp) begin
          upd_kind = KindPtp;
        end else if (typ == EtypeEcpri) begin
          upd_kind = KindEcpri;
        end else begin
          upd_kind = KindOther;
        end
      end
    end

    // eCPRI header bytes, indexed from the L2 offset
    if (done_q && (kind_q == KindEcpri) && !ecnt_q[EcptrW]) begin
      ehdr_d[ecnt_q[EcptrW-1:0]] = rx_i.rx_byte;
      upd_ecnt = ecnt_q + 1'b1;
    end
  end

  // Restart the parse after the last byte
  always_comb begin
    if (rx_i.frame_end) begin
      pos_d  = '0;
      off_d  = L2Offset;
      tags_d = '0;
      pend_d = 1'b0;
      done_d = 1'b0;
      kind_d = KindOther;
      ecnt_d = '0;
    end else begin
      pos_d  = upd_plen;
      off_d  = upd_off;
      tags_d = upd_tags;
      pend_d = upd_pend;
      done_d = upd_done;
      kind_d = upd_kind;
      ecnt_d = upd_ecnt;
    end
  end

  // Frame summary
  assign push_o             = accept && rx_i.frame_end;
  assign frame_o.plen       = upd_plen;
  assign frame_o.off        = upd_off;
  assign frame_o.tags       = upd_tags;
  assign frame_o.typ_done   = upd_done;
  assign frame_o.kind       = upd_kind;
  assign frame_o.vid_outer  = vid0_d;
  assign frame_o.vid_inner  = vid1_d;
  assign frame_o.ehdr       = ehdr_d;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      off_q  <= L2Offset;
      tags_q <= '0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
      kind_q <= KindOther;
      ecnt_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      off_q  <= off_d;
      tags_q <= tags_d;
      pend_q <= pend_d;
      done_q <= done_d;
      kind_q <= kind_d;
      ecnt_q <= ecnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_q <= rx_i.rx_byte;
      vid0_q <= vid0_d;
      vid1_q <= vid1_d;
      ehdr_q <= ehdr_d;
    end
  end

  `ASSERT_PROP(a_off_legal, (off_q == 5'd14) || (off_q == 5'd18) || (off_q == 5'd22), "front: L2 offset out of range")
  `ASSERT_NEVER(a_pend_done, pend_q && (done_q || (tags_q == MaxTags)), "front: tag open after type settled")

endmodule

// ===== src/fhc_queue.sv =====
// ----------------------------------------------------------------------------
// Fronthaul header classifier frame queue
// Short FIFO of frame summaries between the front end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fhc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fhc_pkg::fhc_frame_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output fhc_pkg::fhc_frame_t head_o
);
  import fhc_pkg::*;

  fhc_frame_t       mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q;
  logic [QPtrW-1:0] rd_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth-1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o, "queue: push while full")
  `ASSERT_NEVER(a_no_underflow, pop_i && !valid_o, "queue: pop while empty")

endmodule

// ===== src/fhc_back.sv =====
// ----------------------------------------------------------------------------
// Fronthaul header classifier back end
// Runs the length, revision and size checks on a frame summary and holds
// the result item in an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fhc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  fhc_pkg::fhc_frame_t frame_i,
  output logic                pop_o,
  fhc_res_if.source           res_o
);
  import fhc_pkg::*;

  logic [CountW-1:0] avail;
  logic [CountW-1:0] need;
  logic [15:0]       size;
  logic [7:0]        mtype;
  logic              short_size;
  fhc_result_t       res_d;
  fhc_result_t       res_q;
  logic              out_valid_q;
  logic              bad_plane;

  // Bytes after the L2 offset, and length needed by the payload size
  assign size       = {frame_i.ehdr[2], frame_i.ehdr[3]};
  assign mtype      = frame_i.ehdr[1];
  assign avail      = frame_i.plen - CountW'(frame_i.off);
  assign need       = CountW'(size) + CountW'(frame_i.off) + HdrCommonLen;
  assign short_size = frame_i.plen < need;

  // Result fields
  always_comb begin
    res_d           = '0;
    res_d.vlan_tags = frame_i.tags;
    if (frame_i.tags != 2'd0) begin
      res_d.outer_vlan = frame_i.vid_outer;
    end
    if (frame_i.tags == MaxTags) begin
      res_d.inner_vlan = frame_i.vid_inner;
    end

    if (!frame_i.typ_done) begin
      // too short for Ethernet or for an announced tag
      res_d.malformed = 1'b1;
    end else begin
      unique case (frame_i.kind)
        KindPtp: begin
          res_d.plane = PlanePtp;
        end
        KindEcpri: begin
          if (avail < HdrCommonLen) begin
            res_d.malformed = 1'b1;
          end else begin
            res_d.concat_bit  = frame_i.ehdr[0][0];
            res_d.payload_len = size;
            if ((frame_i.ehdr[0][7:4] != EcpriRev) || short_size) begin
              res_d.malformed = 1'b1;
            end else if ((mtype == MsgIq) || (mtype == MsgRtc)) begin
              if ((size < MinPayload) || (avail < MsgHdrEnd)) begin
                res_d.malformed = 1'b1;
              end else begin
                res_d.eaxc_id = {frame_i.ehdr[4], frame_i.ehdr[5]};
                res_d.seq_id  = {frame_i.ehdr[6], frame_i.ehdr[7]};
                if (avail < AppHdrEnd) begin
                  res_d.malformed = 1'b1;
                end else begin
                  res_d.radio_header_word = {frame_i.ehdr[8], frame_i.ehdr[9],
                                             frame_i.ehdr[10], frame_i.ehdr[11]};
                  if (mtype == MsgIq) begin
                    res_d.plane = PlaneU;
                    if (avail >= USectEnd) begin
                      res_d.section_word = {frame_i.ehdr[12], frame_i.ehdr[13],
                                            frame_i.ehdr[14], frame_i.ehdr[15]};
                    end
                  end else begin
                    res_d.plane = PlaneC;
                    if (avail >= CSectEnd) begin
                      res_d.section_word = {frame_i.ehdr[12], frame_i.ehdr[13], 16'h0000};
                    end
                  end
                end
              end
            end else if (mtype == MsgDelay) begin
              res_d.plane = PlaneDelay;
            end
          end
        end
        default: begin
          res_d.plane = PlaneNone;
        end
      endcase
    end
  end

  // Output register
  assign pop_o = valid_i && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.plane             = res_q.plane;
  assign res_o.malformed         = res_q.malformed;
  assign res_o.vlan_tags         = res_q.vlan_tags;
  assign res_o.outer_vlan        = res_q.outer_vlan;
  assign res_o.inner_vlan        = res_q.inner_vlan;
  assign res_o.concat_bit        = res_q.concat_bit;
  assign res_o.payload_len       = res_q.payload_len;
  assign res_o.eaxc_id           = res_q.eaxc_id;
  assign res_o.seq_id            = res_q.seq_id;
  assign res_o.radio_header_word = res_q.radio_header_word;
  assign res_o.section_word      = res_q.section_word;

  // Malformed item offered with a plane other than none
  assign bad_plane = out_valid_q && res_q.malformed && (res_q.plane != PlaneNone);

  `ASSERT_NEVER(a_malformed_none, bad_plane, "back: malformed item with a plane")

endmodule

// ===== src/fronthaul_header_classifier.sv =====
// ----------------------------------------------------------------------------
// Fronthaul header classifier
// Classifies Ethernet fronthaul frames (PTP, eCPRI U/C-plane, delay) and
// reports VLAN tags and the leading eCPRI / radio header fields.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per clock on rx_i while rx_i.ready is high, with
// no gaps needed between frames; the byte with frame_end set closes the frame
// and yields exactly one result item on res_o via the frame queue and the
// output register. Header fields are captured as the bytes stream past into
// header registers that are not cleared after reset. A two-entry frame
// queue sits between the byte parser and the check/output stage: rx_i.ready
// drops only while that queue is full, i.e. when res_o has been held off.
// ----------------------------------------------------------------------------
module fronthaul_header_classifier (
  input  logic      clk_i,
  input  logic      rst_ni,
  fhc_rx_if.sink    rx_i,
  fhc_res_if.source res_o
);
  import fhc_pkg::*;

  logic       push;
  logic       full;
  logic       pop;
  logic       head_valid;
  fhc_frame_t frame_in;
  fhc_frame_t frame_head;

  fhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .full_i  (full),
    .push_o  (push),
    .frame_o (frame_in)
  );

  fhc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (frame_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (frame_head)
  );

  fhc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .frame_i (frame_head),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
